// ===== hw/rtl/pplcc_pkg.sv =====
package pplcc_pkg;

	// Field widths
	localparam int unsigned LINE_W   = 10;
	localparam int unsigned SETTLE_W = 8;
	localparam int unsigned OP_W     = 3;
	localparam int unsigned CS_W     = 3;
	localparam int unsigned ULINES_W = LINE_W + 1;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = LINE_W;

	localparam logic [LINE_W-1:0]   LINE_MAX           = '1;
	localparam logic [LINE_W-1:0]   LINE_TOTAL_RESET   = LINE_W'(272);
	localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RESET = SETTLE_W'(5);

	// Operation codes
	localparam logic [OP_W-1:0] OP_UPDATE      = 3'd0;
	localparam logic [OP_W-1:0] OP_REQUEST     = 3'd1;
	localparam logic [OP_W-1:0] OP_ABORT       = 3'd2;
	localparam logic [OP_W-1:0] OP_TAKE_UPLOAD = 3'd3;
	localparam logic [OP_W-1:0] OP_UPLOAD_DONE = 3'd4;
	localparam logic [OP_W-1:0] OP_TICK        = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_TOTAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 2'd1;

	// Reported capture state codes
	localparam logic [CS_W-1:0] CS_IDLE      = 3'd0;
	localparam logic [CS_W-1:0] CS_INIT      = 3'd1;
	localparam logic [CS_W-1:0] CS_ACTIVE    = 3'd2;
	localparam logic [CS_W-1:0] CS_COMPLETED = 3'd3;
	localparam logic [CS_W-1:0] CS_ABORT     = 3'd4;

	// Capture mode, one-hot
	typedef enum logic [4:0] {
		MODE_IDLE      = 5'b00001,
		MODE_INIT      = 5'b00010,
		MODE_ACTIVE    = 5'b00100,
		MODE_COMPLETED = 5'b01000,
		MODE_ABORT     = 5'b10000
	} mode_t;

	// Buffer phase, one-hot
	typedef enum logic [7:0] {
		PH_SCAN_IDLE = 8'b0000_0001,
		PH_SCAN_LINE = 8'b0000_0010,
		PH_SCAN_WAIT = 8'b0000_0100,
		PH_SCAN_READ = 8'b0000_1000,
		PH_UPLD_IDLE = 8'b0001_0000,
		PH_UPLD_WAIT = 8'b0010_0000,
		PH_UPLD_ACTV = 8'b0100_0000,
		PH_UPLD_DONE = 8'b1000_0000
	} phase_t;

	// Device answers for one update step
	typedef struct packed {
		logic start_ok;
		logic busy_check_valid;
		logic device_busy;
		logic rgb_ok;
	} dev_t;

	// Capture-wide state and step events passed from buffer to buffer
	typedef struct packed {
		mode_t              mode;
		logic               valid;
		logic [LINE_W-1:0]  next_line;
		logic [SETTLE_W-1:0] settle;
		logic               ev_start;
		logic [LINE_W-1:0]  ev_start_line;
		logic               ev_read;
		logic               ev_read_buf;
	} shared_t;

	function automatic logic [CS_W-1:0] mode_code(input mode_t m);
		logic [CS_W-1:0] c;
		case (m)
			MODE_IDLE:      c = CS_IDLE;
			MODE_INIT:      c = CS_INIT;
			MODE_ACTIVE:    c = CS_ACTIVE;
			MODE_COMPLETED: c = CS_COMPLETED;
			MODE_ABORT:     c = CS_ABORT;
			default:        c = CS_IDLE;
		endcase
		return c;
	endfunction

	function automatic logic in_scan(input phase_t p);
		return (p == PH_SCAN_LINE) || (p == PH_SCAN_WAIT) || (p == PH_SCAN_READ);
	endfunction

endpackage

// ===== hw/rtl/pplcc_ifs.sv =====
// Event word channel
interface pplcc_in_if;
	logic                       valid;
	logic                       ready;
	logic [pplcc_pkg::OP_W-1:0] op;
	logic                       shot_enabled;
	logic                       start_ok;
	logic                       busy_check_valid;
	logic                       device_busy;
	logic                       rgb_ok;

	modport source (output valid, op, shot_enabled, start_ok, busy_check_valid,
		device_busy, rgb_ok, input ready);
	modport sink (input valid, op, shot_enabled, start_ok, busy_check_valid,
		device_busy, rgb_ok, output ready);
endinterface

// Result word channel
interface pplcc_out_if;
	logic                           valid;
	logic                           ready;
	logic [pplcc_pkg::CS_W-1:0]     capture_state;
	logic                           process_active;
	logic                           completed;
	logic                           capture_valid;
	logic                           scan_busy;
	logic                           start_issued;
	logic [pplcc_pkg::LINE_W-1:0]   start_line;
	logic                           rgb_read_done;
	logic                           rgb_buffer;
	logic                           upload_granted;
	logic                           upload_buffer;
	logic [pplcc_pkg::ULINES_W-1:0] upload_lines;

	modport source (output valid, capture_state, process_active, completed,
		capture_valid, scan_busy, start_issued, start_line, rgb_read_done,
		rgb_buffer, upload_granted, upload_buffer, upload_lines, input ready);
	modport sink (input valid, capture_state, process_active, completed,
		capture_valid, scan_busy, start_issued, start_line, rgb_read_done,
		rgb_buffer, upload_granted, upload_buffer, upload_lines, output ready);
endinterface

// Configuration write channel
interface pplcc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pplcc_pkg::CFG_IDX_W-1:0]  index;
	logic [pplcc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pplcc_lane.sv =====
// One buffer's pass through an active update step
module pplcc_lane (
	input  logic                          buf_id,
	input  pplcc_pkg::phase_t             phase_in,
	input  pplcc_pkg::phase_t             other_phase,
	input  logic [pplcc_pkg::LINE_W-1:0]  line_in,
	input  pplcc_pkg::shared_t            shared_in,
	input  pplcc_pkg::dev_t               dev,
	input  logic [pplcc_pkg::LINE_W-1:0]  line_total,
	input  logic [pplcc_pkg::SETTLE_W-1:0] settle_ticks,
	output pplcc_pkg::phase_t             phase_out,
	output logic [pplcc_pkg::LINE_W-1:0]  line_out,
	output pplcc_pkg::shared_t            shared_out
);
	import pplcc_pkg::*;

	always_comb begin
		phase_t            ph;
		logic [LINE_W-1:0] ln;
		shared_t           sh;

		ph = phase_in;
		ln = line_in;
		sh = shared_in;

		// claim the next line when the other buffer is idle or uploading
		if (ph == PH_SCAN_IDLE) begin
			if (((other_phase == PH_SCAN_IDLE) || (other_phase == PH_UPLD_ACTV))
				&& (sh.next_line < line_total)) begin
				ph = PH_SCAN_LINE;
				ln = sh.next_line;
			end
		end

		// line start, held off by the settle countdown
		if ((ph == PH_SCAN_LINE) && (sh.settle == '0)) begin
			if (!sh.ev_start) begin
				sh.ev_start      = 1'b1;
				sh.ev_start_line = ln;
			end
			if (dev.start_ok) begin
				ph = PH_SCAN_WAIT;
			end else begin
				sh.valid = 1'b0;
				sh.mode  = MODE_COMPLETED;
			end
		end

		if (ph == PH_SCAN_WAIT) begin
			if (dev.busy_check_valid && !dev.device_busy) begin
				ph = PH_SCAN_READ;
			end
		end

		// line read
		if (ph == PH_SCAN_READ) begin
			if (dev.rgb_ok) begin
				if (sh.next_line != LINE_MAX) begin
					sh.next_line = sh.next_line + LINE_W'(1);
				end
				sh.settle = settle_ticks;
				ph        = PH_UPLD_IDLE;
				if (!sh.ev_read) begin
					sh.ev_read     = 1'b1;
					sh.ev_read_buf = buf_id;
				end
			end else begin
				sh.valid = 1'b0;
				sh.mode  = MODE_COMPLETED;
			end
		end

		// only one buffer waits for upload at a time
		if (ph == PH_UPLD_IDLE) begin
			if ((other_phase != PH_UPLD_ACTV) && (other_phase != PH_UPLD_WAIT)) begin
				ph = PH_UPLD_WAIT;
			end
		end

		if (ph == PH_UPLD_DONE) begin
			if (sh.next_line >= line_total) begin
				sh.mode = MODE_COMPLETED;
			end else begin
				ph = PH_SCAN_IDLE;
			end
		end

		phase_out  = ph;
		line_out   = ln;
		shared_out = sh;
	end

endmodule

// ===== hw/rtl/ping_pong_line_capture_controller_top.sv =====
// Ping-pong line capture controller.
// cmd: event words (op plus device answers), valid/ready. One word per event:
//   update step, request, abort, take upload, upload done, settle tick.
// res: one result word per event word, giving the capture state after that
//   event plus this step's line start, line read and upload grant.
// cfg: register writes (index 0 line_total, index 1 settle_ticks); always
//   ready, to be written only while no event is in flight.
// Result word: registered when its event is accepted. Throughput: one
//   event per cycle while cmd.ready is high. The whole step, both buffers
//   in order, is one pass of logic between the state and result registers.
// Stall: cmd.ready is high while the result register is empty or being
//   taken, so a held result blocks only the next event word.
// Reset: capture idle, no request, both buffers scan idle, counters zero,
//   line_total 272, settle_ticks 5, result register empty.
module ping_pong_line_capture_controller_top (
	input logic        clk,
	input logic        arst_n,
	pplcc_in_if.sink   cmd,
	pplcc_out_if.source res,
	pplcc_cfg_if.sink  cfg
);
	import pplcc_pkg::*;

	// configuration
	logic [LINE_W-1:0]   line_total_q;
	logic [SETTLE_W-1:0] settle_ticks_q;

	// capture state
	mode_t               mode_q, mode_d;
	logic                req_q, req_d;
	logic                valid_q, valid_d;
	logic [LINE_W-1:0]   next_line_q, next_line_d;
	logic [SETTLE_W-1:0] settle_q, settle_d;
	phase_t              phase0_q, phase0_d, phase1_q, phase1_d;
	logic [LINE_W-1:0]   line0_q, line0_d, line1_q, line1_d;

	// result register
	logic                out_valid_q;
	logic [CS_W-1:0]     cs_q;
	logic                pact_q, compl_q, cvalid_q, sbusy_q;
	logic                start_q, rd_q, rdbuf_q, grant_q, gbuf_q;
	logic [LINE_W-1:0]   sline_q;
	logic [ULINES_W-1:0] glines_q;

	logic                accept;
	logic                grant, gbuf;
	logic [ULINES_W-1:0] glines;
	shared_t             sh_base, sh_mid, sh_end, sh_d;
	phase_t              lane0_ph, lane1_ph;
	logic [LINE_W-1:0]   lane0_ln, lane1_ln;
	dev_t                dev;

	assign cmd.ready = !out_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	assign dev.start_ok         = cmd.start_ok;
	assign dev.busy_check_valid = cmd.busy_check_valid;
	assign dev.device_busy      = cmd.device_busy;
	assign dev.rgb_ok           = cmd.rgb_ok;

	always_comb begin
		sh_base               = '0;
		sh_base.mode          = mode_q;
		sh_base.valid         = valid_q;
		sh_base.next_line     = next_line_q;
		sh_base.settle        = settle_q;
	end

	// buffer 0 then buffer 1, chained
	pplcc_lane u_lane0 (
		.buf_id       (1'b0),
		.phase_in     (phase0_q),
		.other_phase  (phase1_q),
		.line_in      (line0_q),
		.shared_in    (sh_base),
		.dev          (dev),
		.line_total   (line_total_q),
		.settle_ticks (settle_ticks_q),
		.phase_out    (lane0_ph),
		.line_out     (lane0_ln),
		.shared_out   (sh_mid)
	);

	pplcc_lane u_lane1 (
		.buf_id       (1'b1),
		.phase_in     (phase1_q),
		.other_phase  (lane0_ph),
		.line_in      (line1_q),
		.shared_in    (sh_mid),
		.dev          (dev),
		.line_total   (line_total_q),
		.settle_ticks (settle_ticks_q),
		.phase_out    (lane1_ph),
		.line_out     (lane1_ln),
		.shared_out   (sh_end)
	);

	// next state for one event
	always_comb begin
		mode_d      = mode_q;
		req_d       = req_q;
		valid_d     = valid_q;
		next_line_d = next_line_q;
		settle_d    = settle_q;
		phase0_d    = phase0_q;
		phase1_d    = phase1_q;
		line0_d     = line0_q;
		line1_d     = line1_q;
		sh_d        = '0;
		grant       = 1'b0;
		gbuf        = 1'b0;
		glines      = '0;

		case (cmd.op)
			OP_UPDATE: begin
				// a pending request restarts the capture
				if (req_q) begin
					mode_d = MODE_INIT;
					req_d  = 1'b0;
				end
				case (mode_d)
					MODE_INIT: begin
						if (cmd.shot_enabled) begin
							valid_d     = 1'b1;
							next_line_d = '0;
							settle_d    = '0;
							mode_d      = MODE_ACTIVE;
							phase0_d    = PH_SCAN_LINE;
							line0_d     = '0;
							phase1_d    = PH_SCAN_IDLE;
							line1_d     = '0;
						end else begin
							valid_d = 1'b0;
							mode_d  = MODE_COMPLETED;
						end
					end
					MODE_ACTIVE: begin
						sh_d        = sh_end;
						mode_d      = sh_end.mode;
						valid_d     = sh_end.valid;
						next_line_d = sh_end.next_line;
						settle_d    = sh_end.settle;
						phase0_d    = lane0_ph;
						line0_d     = lane0_ln;
						phase1_d    = lane1_ph;
						line1_d     = lane1_ln;
					end
					MODE_ABORT: begin
						mode_d = MODE_IDLE;
					end
					default: begin
					end
				endcase
			end
			OP_REQUEST: begin
				req_d = 1'b1;
			end
			OP_ABORT: begin
				mode_d = MODE_ABORT;
			end
			OP_TAKE_UPLOAD: begin
				// buffer 0 has priority
				if (phase0_q == PH_UPLD_WAIT) begin
					grant    = 1'b1;
					glines   = {1'b0, line0_q} + ULINES_W'(1);
					phase0_d = PH_UPLD_ACTV;
				end else if (phase1_q == PH_UPLD_WAIT) begin
					grant    = 1'b1;
					gbuf     = 1'b1;
					glines   = {1'b0, line1_q} + ULINES_W'(1);
					phase1_d = PH_UPLD_ACTV;
				end
			end
			OP_UPLOAD_DONE: begin
				if (phase0_q == PH_UPLD_ACTV) begin
					phase0_d = PH_UPLD_DONE;
				end else begin
					phase1_d = PH_UPLD_DONE;
				end
			end
			OP_TICK: begin
				if (settle_q != '0) begin
					settle_d = settle_q - SETTLE_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_total_q   <= LINE_TOTAL_RESET;
			settle_ticks_q <= SETTLE_TICKS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LINE_TOTAL:   line_total_q   <= cfg.data[LINE_W-1:0];
				REG_SETTLE_TICKS: settle_ticks_q <= cfg.data[SETTLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// capture state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			req_q       <= 1'b0;
			valid_q     <= 1'b0;
			next_line_q <= '0;
			settle_q    <= '0;
			phase0_q    <= PH_SCAN_IDLE;
			phase1_q    <= PH_SCAN_IDLE;
			line0_q     <= '0;
			line1_q     <= '0;
		end else if (accept) begin
			mode_q      <= mode_d;
			req_q       <= req_d;
			valid_q     <= valid_d;
			next_line_q <= next_line_d;
			settle_q    <= settle_d;
			phase0_q    <= phase0_d;
			phase1_q    <= phase1_d;
			line0_q     <= line0_d;
			line1_q     <= line1_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cs_q     <= mode_code(mode_d);
			pact_q   <= (mode_d != MODE_IDLE) || req_d;
			compl_q  <= (mode_d == MODE_COMPLETED);
			cvalid_q <= valid_d;
			sbusy_q  <= in_scan(phase0_d) || in_scan(phase1_d);
			start_q  <= sh_d.ev_start;
			sline_q  <= sh_d.ev_start_line;
			rd_q     <= sh_d.ev_read;
			rdbuf_q  <= sh_d.ev_read_buf;
			grant_q  <= grant;
			gbuf_q   <= gbuf;
			glines_q <= glines;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.capture_state  = cs_q;
	assign res.process_active = pact_q;
	assign res.completed      = compl_q;
	assign res.capture_valid  = cvalid_q;
	assign res.scan_busy      = sbusy_q;
	assign res.start_issued   = start_q;
	assign res.start_line     = sline_q;
	assign res.rgb_read_done  = rd_q;
	assign res.rgb_buffer     = rdbuf_q;
	assign res.upload_granted = grant_q;
	assign res.upload_buffer  = gbuf_q;
	assign res.upload_lines   = glines_q;

endmodule
